FILE: hdl/ple_pkg.sv
// Package for the positional list engine: sizes, codes, request and result types.
package ple_pkg;

    // List sizing.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 3;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_AT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_ALL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINAL,
        S_DONE
    } t_state;

    // One request.
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [LEN_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    // One result.
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [ADDR_W-1:0]        found_index;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         removed_count;
        logic [LEN_W-1:0]         length_after;
    } t_res;

    // Handshake between the output stage and the sequencer.
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

endpackage

FILE: hdl/ple_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ple_core.sv
// Sequencer that walks the element store one entry per cycle through a shared compare unit.
module ple_core import ple_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_req       i_req,
    input  logic       i_take,
    output t_core_stat o_stat,
    output t_res       o_res
);

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [KIND_W-1:0] r_mode, n_mode;
    logic [DATA_W-1:0] r_value, n_value;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic [LEN_W-1:0]  r_rd_left, n_rd_left;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_idx, n_pend_idx;
    logic [ADDR_W-1:0] r_wr_idx, n_wr_idx;
    logic [LEN_W-1:0]  r_removed, n_removed;
    logic [ADDR_W-1:0] r_found, n_found;
    logic [DATA_W-1:0] r_rdval, n_rdval;
    logic [STAT_W-1:0] r_status, n_status;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              w_match;
    logic [LEN_W-1:0]  w_pos;

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The shared compare unit: the entry just read against the request value.
    assign w_match = (ram_rdata == r_value);
    assign w_pos   = i_req.position;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pend  <= n_pend;
        end
    end

    // Walk and result registers.
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_value    <= n_value;
        r_pos      <= n_pos;
        r_rd_idx   <= n_rd_idx;
        r_rd_left  <= n_rd_left;
        r_pend_idx <= n_pend_idx;
        r_wr_idx   <= n_wr_idx;
        r_removed  <= n_removed;
        r_found    <= n_found;
        r_rdval    <= n_rdval;
        r_status   <= n_status;
    end

    // Next state and memory control.
    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_mode     = r_mode;
        n_value    = r_value;
        n_pos      = r_pos;
        n_rd_idx   = r_rd_idx;
        n_rd_left  = r_rd_left;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_wr_idx   = r_wr_idx;
        n_removed  = r_removed;
        n_found    = r_found;
        n_rdval    = r_rdval;
        n_status   = r_status;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_rd_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode    = i_req.kind;
                    n_value   = i_req.value;
                    n_pos     = i_req.position[ADDR_W-1:0];
                    n_removed = '0;
                    n_found   = '0;
                    n_rdval   = '0;
                    n_status  = ST_OK;
                    n_state   = S_DONE;
                    // Decode the request and set up the walk.
                    unique case (i_req.kind) inside
                        KIND_INSERT: begin
                            if (r_len >= LEN_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (w_pos > r_len) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_len = r_len + 1'b1;
                                if (w_pos == r_len) begin
                                    n_state = S_FINAL;
                                end else begin
                                    n_rd_idx  = ADDR_W'(r_len - 1'b1);
                                    n_rd_left = r_len - w_pos;
                                    n_state   = S_WALK;
                                end
                            end
                        end
                        KIND_DEL_AT: begin
                            if (r_len == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos >= r_len) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_len     = r_len - 1'b1;
                                n_removed = LEN_W'(1);
                                n_rd_idx  = ADDR_W'(w_pos + 1'b1);
                                n_rd_left = r_len - w_pos - 1'b1;
                                n_wr_idx  = w_pos[ADDR_W-1:0];
                                n_state   = S_WALK;
                            end
                        end
                        KIND_DEL_ALL, KIND_SEARCH: begin
                            if (r_len == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                if (i_req.kind == KIND_SEARCH) begin
                                    n_status = ST_NOTFOUND;
                                end
                                n_rd_idx  = '0;
                                n_rd_left = r_len;
                                n_wr_idx  = '0;
                                n_state   = S_WALK;
                            end
                        end
                        KIND_READ: begin
                            if (r_len == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos >= r_len) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_rd_idx  = w_pos[ADDR_W-1:0];
                                n_rd_left = LEN_W'(1);
                                n_state   = S_WALK;
                            end
                        end
                        KIND_CLEAR: begin
                            if (r_len == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_removed = r_len;
                                n_len     = '0;
                            end
                        end
                        default: begin
                            // Unused kinds leave the list alone.
                        end
                    endcase
                end
            end

            S_WALK: begin
                // Issue the next read while entries remain.
                if (r_rd_left != '0) begin
                    ram_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx;
                    n_rd_left  = r_rd_left - 1'b1;
                    if (r_mode == KIND_INSERT) begin
                        n_rd_idx = r_rd_idx - 1'b1;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end

                // Handle the entry read in the previous cycle.
                if (r_pend) begin
                    case (r_mode) inside
                        KIND_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pend_idx + 1'b1;
                            ram_wdata = ram_rdata;
                        end
                        KIND_DEL_AT, KIND_DEL_ALL: begin
                            if (r_mode == KIND_DEL_ALL && w_match) begin
                                n_removed = r_removed + 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_wr_idx;
                                ram_wdata = ram_rdata;
                                n_wr_idx  = r_wr_idx + 1'b1;
                            end
                        end
                        KIND_SEARCH: begin
                            if (w_match) begin
                                n_status  = ST_OK;
                                n_found   = r_pend_idx;
                                n_rd_left = '0;
                                n_pend    = 1'b0;
                                ram_re    = 1'b0;
                            end
                        end
                        default: begin
                            n_rdval = ram_rdata;
                        end
                    endcase
                end

                // The walk ends once nothing is issued or outstanding.
                if (r_rd_left == '0 && !r_pend) begin
                    if (r_mode == KIND_INSERT) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state = S_DONE;
                        if (r_mode == KIND_DEL_ALL) begin
                            n_len = r_len - r_removed;
                            if (r_removed == '0) begin
                                n_status = ST_NOTFOUND;
                            end
                        end
                    end
                end
            end

            S_FINAL: begin
                // Drop the new value into the opened slot.
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_value;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stat.idle         = (r_state == S_IDLE);
    assign o_stat.done         = (r_state == S_DONE);
    assign o_res.status        = r_status;
    assign o_res.found_index   = r_found;
    assign o_res.read_value    = r_rdval;
    assign o_res.removed_count = r_removed;
    assign o_res.length_after  = r_len;

endmodule

FILE: hdl/positional_list_engine.sv
// Top level of the positional list engine: request intake and the result register.
//
// An ordered list of up to CAPACITY signed 32-bit values. A request arrives on
// i_req_valid / o_req_ready with i_req (kind, position, value) and is taken at
// a rising edge where both are high. Each request yields exactly one result on
// o_res_valid / i_res_ready with o_res (status, found_index, read_value,
// removed_count, length_after), in request order.
// Read-free kinds, errors and clear finish without walking the list; insert,
// delete, delete-all and search stream the list through the single read port
// of the element store, one entry per cycle,
// with one equality compare per entry. One request is worked on at a time;
// o_req_ready is high whenever the sequencer is idle.
// A finished result sits in the output register, and a new request is taken
// while it waits. If the receiver stalls, the next finished result is held in
// the sequencer until the output register frees up.
// Synchronous reset (i_rst_n low) empties the list and drops any result; the
// element store itself is not cleared and needs no start-up pass.
module positional_list_engine import ple_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    t_core_stat core_stat;
    t_res       core_res;
    logic       w_start;
    logic       w_load;
    logic       r_out_valid;
    t_res       r_out;

    assign o_req_ready = core_stat.idle;
    assign w_start     = i_req_valid && core_stat.idle;
    assign w_load      = core_stat.done && (!r_out_valid || i_res_ready);

    ple_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (i_req),
        .i_take  (w_load),
        .o_stat  (core_stat),
        .o_res   (core_res)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= core_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

FILE: verif/tb_top.sv
// Testbench for the positional list engine: directed and random requests checked against a list mirror.
module tb_top import ple_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Kinds the block has no operation for; it must leave the list alone.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS   = 800;
    localparam int FILL_ITEMS     = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE      = 8;

    // Mirror of the list contents; predicts one result per request and
    // checks the block's results in order.
    class list_mirror;
        logic [DATA_W-1:0] entries [CAPACITY];
        int                list_len;
        t_res              expected_results [$];
        int                errors;

        function new();
            list_len = 0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Work out the result of an accepted request and update the mirror.
        function void note_request(t_req rq);
            t_res r;
            int   len;
            int   pos;
            int   w;
            int   removed;
            r       = '0;
            len     = list_len;
            pos     = int'(rq.position);
            removed = 0;
            case (rq.kind)
                KIND_INSERT: begin
                    // A full list is reported before the position is looked at.
                    if (len >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else if (pos > len) begin
                        r.status = ST_BADPOS;
                    end else begin
                        for (int i = len; i > pos; i--)
                            entries[i] = entries[i - 1];
                        entries[pos] = rq.value;
                        len++;
                    end
                end
                KIND_DEL_AT: begin
                    if (len == 0) begin
                        r.status = ST_EMPTY;
                    end else if (pos >= len) begin
                        r.status = ST_BADPOS;
                    end else begin
                        for (int i = pos; i + 1 < len; i++)
                            entries[i] = entries[i + 1];
                        len--;
                        removed = 1;
                    end
                end
                KIND_DEL_ALL: begin
                    if (len == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // Compact the survivors toward the front, keeping order.
                        w = 0;
                        for (int i = 0; i < len; i++) begin
                            if (entries[i] == rq.value) begin
                                removed++;
                            end else begin
                                entries[w] = entries[i];
                                w++;
                            end
                        end
                        len = w;
                        if (removed == 0)
                            r.status = ST_NOTFOUND;
                    end
                end
                KIND_SEARCH: begin
                    if (len == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.status = ST_NOTFOUND;
                        for (int i = 0; i < len; i++) begin
                            if (entries[i] == rq.value) begin
                                r.status      = ST_OK;
                                r.found_index = ADDR_W'(i);
                                break;
                            end
                        end
                    end
                end
                KIND_READ: begin
                    if (len == 0)
                        r.status = ST_EMPTY;
                    else if (pos >= len)
                        r.status = ST_BADPOS;
                    else
                        r.read_value = entries[pos];
                end
                KIND_CLEAR: begin
                    if (len == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        removed = len;
                        len     = 0;
                    end
                end
                default: begin
                end
            endcase
            list_len        = len;
            r.removed_count = LEN_W'(removed);
            r.length_after  = LEN_W'(len);
            expected_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
            end
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(t_res got);
            t_res exp_r;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, expected none, actual %0h",
                         $time, got);
                return;
            end
            exp_r = expected_results.pop_front();
            compare("status", 32'(exp_r.status), 32'(got.status));
            compare("found_index", 32'(exp_r.found_index), 32'(got.found_index));
            compare("read_value", exp_r.read_value, got.read_value);
            compare("removed_count", 32'(exp_r.removed_count), 32'(got.removed_count));
            compare("length_after", 32'(exp_r.length_after), 32'(got.length_after));
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_res_valid;
    logic i_res_ready = 1'b0;
    t_res o_res;

    list_mirror        mirror;
    logic [DATA_W-1:0] value_pool [POOL_SIZE];
    int                sender_idle_pct;
    int                receiver_idle_pct;
    bit                start_hold = 1'b0;
    int                hold_left  = 0;
    int                quiet_cycles = 0;

    positional_list_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready),
        .o_res      (o_res)
    );

    // 50 MHz clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (start_hold) begin
            hold_left  = HOLD_CYCLES;
            start_hold = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Result check and watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            mirror.check_result(o_res);
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_res_valid && i_res_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Offer one request after a random gap and wait until it is taken.
    task automatic send_req(input t_req rq);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= rq;
        do
            @(posedge i_clk);
        while (!o_req_ready);
        mirror.note_request(rq);
    endtask

    task automatic send_fields(input logic [KIND_W-1:0] kind, input int pos,
                               input logic [DATA_W-1:0] value);
        t_req rq;
        rq.kind     = kind;
        rq.position = LEN_W'(pos);
        rq.value    = value;
        send_req(rq);
    endtask

    // Stop offering requests until every predicted result has come back.
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending() != 0)
            @(posedge i_clk);
    endtask

    // Random request; positions are mostly legal for the current length and
    // values mostly come from a small pool so searches and deletes hit.
    function automatic t_req random_req(input int len, input bit fill_mode);
        t_req rq;
        int   pick;
        pick = $urandom_range(99);
        if (fill_mode || pick < 40)
            rq.kind = KIND_INSERT;
        else if (pick < 54)
            rq.kind = KIND_DEL_AT;
        else if (pick < 62)
            rq.kind = KIND_DEL_ALL;
        else if (pick < 76)
            rq.kind = KIND_SEARCH;
        else if (pick < 94)
            rq.kind = KIND_READ;
        else if (pick < 97)
            rq.kind = KIND_CLEAR;
        else
            rq.kind = pick[0] ? KIND_SPARE_LO : KIND_SPARE_HI;
        if ($urandom_range(99) < 70)
            rq.value = value_pool[$urandom_range(POOL_SIZE - 1)];
        else
            rq.value = $urandom();
        if ($urandom_range(99) < 90) begin
            if (rq.kind == KIND_INSERT)
                rq.position = LEN_W'($urandom_range(len));
            else
                rq.position = (len == 0) ? '0 : LEN_W'($urandom_range(len - 1));
        end else begin
            rq.position = LEN_W'($urandom_range(127));
        end
        return rq;
    endfunction

    initial begin
        int errors;
        int fill_left;
        mirror = new();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();
        sender_idle_pct   = 25;
        receiver_idle_pct = 69;
        fill_left         = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Everything on an empty list.
        send_fields(KIND_CLEAR, 0, 32'h0);
        send_fields(KIND_DEL_AT, 0, 32'h0);
        send_fields(KIND_DEL_ALL, 0, 32'h0);
        send_fields(KIND_SEARCH, 0, 32'h0);
        send_fields(KIND_READ, 0, 32'h0);
        send_fields(KIND_INSERT, 1, 32'h1234_5678);
        // Build a short list with the value extremes.
        send_fields(KIND_INSERT, 0, 32'h8000_0000);
        send_fields(KIND_INSERT, 1, 32'h7FFF_FFFF);
        send_fields(KIND_INSERT, 0, 32'hFFFF_FFFF);
        send_fields(KIND_INSERT, 3, 32'h7FFF_FFFF);
        send_fields(KIND_INSERT, 127, 32'h0);
        // Reads in range, at the end and far past it.
        send_fields(KIND_READ, 0, 32'h0);
        send_fields(KIND_READ, 3, 32'hFFFF_FFFF);
        send_fields(KIND_READ, 4, 32'h0);
        send_fields(KIND_READ, 64, 32'h0);
        // Search hit and miss, delete-all with two matches and with none.
        send_fields(KIND_SEARCH, 0, 32'h7FFF_FFFF);
        send_fields(KIND_SEARCH, 0, 32'h0000_3039);
        send_fields(KIND_DEL_ALL, 0, 32'h7FFF_FFFF);
        send_fields(KIND_DEL_ALL, 0, 32'h0000_0005);
        // Delete one past the end, which is refused, then at the front.
        send_fields(KIND_DEL_AT, 2, 32'h0);
        send_fields(KIND_DEL_AT, 0, 32'h0);
        // Spare kinds leave the list as it is.
        send_fields(KIND_SPARE_LO, 0, 32'hA5A5_A5A5);
        send_fields(KIND_SPARE_HI, 127, 32'h5A5A_5A5A);
        // Clear of a non-empty list.
        send_fields(KIND_INSERT, 0, 32'h5A5A_5A5A);
        send_fields(KIND_CLEAR, 0, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Second third: pause until drained, then swap the idle rates.
            if (n == RANDOM_ITEMS / 3) begin
                wait_drained();
                sender_idle_pct   = 69;
                receiver_idle_pct = 25;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            // Long receiver stall while requests keep coming.
            if (n == 2 * RANDOM_ITEMS / 3 + 20)
                start_hold = 1'b1;
            // Bursts of inserts push the list to full.
            if (n % 250 == 100)
                fill_left = FILL_ITEMS;
            send_req(random_req(mirror.list_len, fill_left > 0));
            if (fill_left > 0)
                fill_left--;
        end
        i_req_valid <= 1'b0;

        while (mirror.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        errors = mirror.errors;
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/ple_pkg.sv
hdl/ple_ram.sv
hdl/ple_core.sv
hdl/positional_list_engine.sv
verif/tb_top.sv
